// File: sv/upv_pkg.sv
`timescale 1ns / 1ps

package upv_pkg;

	localparam int PATH_MAX_LEN      = 1024;
	localparam int COMPONENT_MAX_LEN = 255;

	localparam int CNT_W  = 11;
	localparam int COMP_W = 9;
	localparam int CAP_W  = 11;

	localparam logic [CNT_W-1:0]  CNT_SAT   = CNT_W'(PATH_MAX_LEN + 1);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(PATH_MAX_LEN);
	localparam logic [COMP_W-1:0] COMP_SAT  = COMP_W'(COMPONENT_MAX_LEN + 1);
	localparam logic [COMP_W-1:0] COMP_MAX  = COMP_W'(COMPONENT_MAX_LEN);
	localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(1025);

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef struct packed {
		logic [7:0] path_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic             path_status;
		logic [CNT_W-1:0] normalized_length;
	} out_item_t;

	// Kind of a byte seen where no continuation byte is expected
	typedef enum logic [3:0] {
		LEAD_ASCII,
		LEAD_TWO,
		LEAD_E0,
		LEAD_ED,
		LEAD_THREE,
		LEAD_F0,
		LEAD_F4,
		LEAD_FOUR,
		LEAD_BAD
	} lead_t;

	typedef enum logic [1:0] {
		RANGE_NORMAL,
		RANGE_RAISED,
		RANGE_LOWERED
	} range_t;

	typedef enum logic [1:0] {
		DOTS_NONE,
		DOTS_ONE,
		DOTS_TWO,
		DOTS_MANY
	} dots_t;

	typedef struct packed {
		logic [7:0] path_byte;
		logic       last_byte;
		logic       bad_char;
		logic       slash;
		logic       reserved;
		logic       digit;
		logic       dot;
		lead_t      lead;
	} class_t;

endpackage

// File: sv/utf8_path_validator.sv
`timescale 1ns / 1ps
// Streaming UTF-8 path checker. Path bytes arrive on the in channel
// (in_valid/in_ready, in_data), one transaction per byte, with last_byte
// set on the final byte of a path. For each path exactly one verdict
// transaction leaves on the out channel (out_valid/out_ready, out_data)
// after its final byte: path_status and the normalised length.
// Bytes are classified on entry and held in a two-entry queue; the back
// end updates the running path state from the queue head and registers
// each verdict as it takes the final byte. It takes one byte per cycle,
// so the block sustains one byte per cycle, while the receiver keeps up.
// If the receiver stalls, the verdict waits in the output register while
// further bytes of the next path are still consumed; only the next final
// byte waits for the output register to drain, and the queue then fills
// and in_ready drops.
// Reset clears the queue, the path state and out_valid, and sets the
// capacity register to 1025. cfg_we writes the capacity register directly.
module utf8_path_validator
	import upv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data
);

	class_t cls_in;
	class_t cls_head;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;
	logic   q_push;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	upv_front u_front (
		.item (in_data),
		.cls  (cls_in)
	);

	upv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (cls_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (cls_head),
		.empty     (q_empty)
	);

	upv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.item_valid (!q_empty),
		.item       (cls_head),
		.item_take  (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// File: sv/upv_front.sv
`timescale 1ns / 1ps

module upv_front
	import upv_pkg::*;
(
	input  in_item_t item,
	output class_t   cls
);

	logic [7:0] b;

	assign b = item.path_byte;

	always_comb begin
		cls.path_byte = b;
		cls.last_byte = item.last_byte;
		cls.bad_char  = (b < CH_SPACE) || (b == CH_DEL) || (b == CH_BSL);
		cls.slash     = (b == CH_SLASH);
		cls.dot       = (b == CH_DOT);
		cls.digit     = (b >= 8'h30) && (b <= 8'h39);
		cls.reserved  = (b == 8'h3A) || (b == 8'h2A) || (b == 8'h3F) || (b == 8'h22) ||
				(b == 8'h3C) || (b == 8'h3E) || (b == 8'h7C);
		case (b) inside
			[8'h00:8'h7F]: cls.lead = LEAD_ASCII;
			[8'hC2:8'hDF]: cls.lead = LEAD_TWO;
			8'hE0:         cls.lead = LEAD_E0;
			8'hED:         cls.lead = LEAD_ED;
			[8'hE1:8'hEF]: cls.lead = LEAD_THREE;
			8'hF0:         cls.lead = LEAD_F0;
			8'hF4:         cls.lead = LEAD_F4;
			[8'hF1:8'hF3]: cls.lead = LEAD_FOUR;
			default:       cls.lead = LEAD_BAD;
		endcase
	end

endmodule

// File: sv/upv_queue.sv
`timescale 1ns / 1ps

module upv_queue
	import upv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  class_t push_data,
	output logic   full,
	input  logic   pop,
	output class_t pop_data,
	output logic   empty
);

	class_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: sv/upv_back.sv
`timescale 1ns / 1ps

module upv_back
	import upv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data,
	input  logic             item_valid,
	input  class_t           item,
	output logic             item_take,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        pend_q;
	range_t            range_q;
	logic [COMP_W-1:0] clen_q;
	dots_t             dots_q;
	logic [7:0]        prev_q;
	logic              err_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic [CNT_W-1:0]  cnt_d;
	logic [1:0]        pend_d;
	range_t            range_d;
	logic [COMP_W-1:0] clen_d;
	dots_t             dots_d;
	logic              err_d;
	logic [CNT_W-1:0]  norm;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	// Only the final byte of a path needs the output slot.
	assign item_take = item_valid && (!item.last_byte || out_free);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		logic [7:0] lo;
		logic [7:0] hi;
		logic       first;
		logic [7:0] b;

		b       = item.path_byte;
		first   = (cnt_q == '0);
		cnt_d   = (cnt_q < CNT_SAT) ? cnt_q + CNT_W'(1) : cnt_q;
		err_d   = err_q || item.bad_char;
		pend_d  = pend_q;
		range_d = range_q;
		clen_d  = clen_q;
		dots_d  = dots_q;
		lo      = 8'h80;
		hi      = 8'hBF;

		if (pend_q != 2'd0) begin
			if (range_q == RANGE_RAISED) lo = (pend_q == 2'd3) ? 8'h90 : 8'hA0;
			else if (range_q == RANGE_LOWERED) hi = (pend_q == 2'd3) ? 8'h8F : 8'h9F;
			if (b < lo || b > hi) begin
				err_d  = 1'b1;
				pend_d = 2'd0;
			end else begin
				pend_d = pend_q - 2'd1;
			end
			range_d = RANGE_NORMAL;
		end else begin
			case (item.lead)
				LEAD_ASCII: ;
				LEAD_TWO: begin
					pend_d = 2'd1; range_d = RANGE_NORMAL;
				end
				LEAD_E0: begin
					pend_d = 2'd2; range_d = RANGE_RAISED;
				end
				LEAD_ED: begin
					pend_d = 2'd2; range_d = RANGE_LOWERED;
				end
				LEAD_THREE: begin
					pend_d = 2'd2; range_d = RANGE_NORMAL;
				end
				LEAD_F0: begin
					pend_d = 2'd3; range_d = RANGE_RAISED;
				end
				LEAD_F4: begin
					pend_d = 2'd3; range_d = RANGE_LOWERED;
				end
				LEAD_FOUR: begin
					pend_d = 2'd3; range_d = RANGE_NORMAL;
				end
				default: begin
					err_d = 1'b1; range_d = RANGE_NORMAL;
				end
			endcase
		end

		if (first) begin
			if (!item.slash) err_d = 1'b1;
		end else if (item.slash) begin
			// A slash closes the component; it is judged by its last byte.
			if (clen_q == '0 || clen_q > COMP_MAX || dots_q == DOTS_ONE ||
					dots_q == DOTS_TWO || prev_q == CH_DOT || prev_q == CH_SPACE)
				err_d = 1'b1;
			clen_d = '0;
			dots_d = DOTS_NONE;
		end else begin
			if (item.reserved) err_d = 1'b1;
			if (prev_q == CH_TILDE && item.digit) err_d = 1'b1;
			if (item.dot) begin
				if (clen_q == '0) dots_d = DOTS_ONE;
				else if (dots_q == DOTS_ONE) dots_d = DOTS_TWO;
				else if (dots_q == DOTS_TWO) dots_d = DOTS_MANY;
			end else begin
				dots_d = DOTS_NONE;
			end
			if (clen_q < COMP_SAT) clen_d = clen_q + COMP_W'(1);
			if (item.last_byte) begin
				if (clen_d > COMP_MAX || dots_d == DOTS_ONE || dots_d == DOTS_TWO ||
						b == CH_DOT || b == CH_SPACE)
					err_d = 1'b1;
			end
		end

		if (item.last_byte) begin
			if (pend_d != 2'd0) err_d = 1'b1;
			if (cnt_d > CNT_MAX) err_d = 1'b1;
			if ({1'b0, cap_q} < ({1'b0, cnt_d} + (CNT_W + 1)'(1))) err_d = 1'b1;
		end

		norm = (item.slash && cnt_d > CNT_W'(1)) ? cnt_d - CNT_W'(1) : cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			cnt_q       <= '0;
			pend_q      <= 2'd0;
			range_q     <= RANGE_NORMAL;
			clen_q      <= '0;
			dots_q      <= DOTS_NONE;
			prev_q      <= 8'h00;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (item_take && item.last_byte)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (item_take) begin
				if (item.last_byte) begin
					cnt_q       <= '0;
					pend_q      <= 2'd0;
					range_q     <= RANGE_NORMAL;
					clen_q      <= '0;
					dots_q      <= DOTS_NONE;
					prev_q      <= 8'h00;
					err_q       <= 1'b0;
				end else begin
					cnt_q   <= cnt_d;
					pend_q  <= pend_d;
					range_q <= range_d;
					clen_q  <= clen_d;
					dots_q  <= dots_d;
					prev_q  <= item.path_byte;
					err_q   <= err_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && item.last_byte) begin
			out_data_q.path_status       <= err_d;
			out_data_q.normalized_length <= err_d ? '0 : norm;
		end
	end

endmodule

// File: verif/upv_verdict_check.sv
`timescale 1ns / 1ps

module upv_verdict_check
	import upv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data,
	output int unsigned      verdicts_owed,
	output int unsigned      fault_count
);

	logic [CAP_W-1:0] capacity;
	int unsigned      path_len;
	logic [1:0]       cont_left;
	range_t           cont_range;
	int unsigned      comp_len;
	dots_t            comp_dots;
	logic [7:0]       prev_byte;
	logic             path_bad;
	out_item_t        owed[$];
	out_item_t        want;

	function automatic void restart_path();
		path_len   = 0;
		cont_left  = 2'd0;
		cont_range = RANGE_NORMAL;
		comp_len   = 0;
		comp_dots  = DOTS_NONE;
		prev_byte  = 8'h00;
		path_bad   = 1'b0;
	endfunction

	function automatic void close_component(input logic [7:0] tail);
		if (comp_len == 0 || comp_len > COMPONENT_MAX_LEN || comp_dots == DOTS_ONE ||
		    comp_dots == DOTS_TWO || tail == CH_DOT || tail == CH_SPACE)
			path_bad = 1'b1;
		comp_len  = 0;
		comp_dots = DOTS_NONE;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b, input logic fin);
		logic        opening;
		logic [7:0]  lo;
		logic [7:0]  hi;
		int unsigned norm;
		out_item_t   verdict;
		opening = (path_len == 0);
		if (path_len < PATH_MAX_LEN + 1)
			path_len++;
		if (b < CH_SPACE || b == CH_DEL || b == CH_BSL)
			path_bad = 1'b1;

		// UTF-8 decoding: the first continuation after E0, ED, F0 and F4 has a narrowed range.
		if (cont_left != 2'd0) begin
			lo = 8'h80;
			hi = 8'hBF;
			if (cont_range == RANGE_RAISED)
				lo = (cont_left == 2'd3) ? 8'h90 : 8'hA0;
			else if (cont_range == RANGE_LOWERED)
				hi = (cont_left == 2'd3) ? 8'h8F : 8'h9F;
			if (b < lo || b > hi) begin
				path_bad  = 1'b1;
				cont_left = 2'd0;
			end else begin
				cont_left--;
			end
			cont_range = RANGE_NORMAL;
		end else if (b >= 8'h80) begin
			cont_range = RANGE_NORMAL;
			if (b >= 8'hC2 && b <= 8'hDF) begin
				cont_left = 2'd1;
			end else if (b == 8'hE0) begin
				cont_left  = 2'd2;
				cont_range = RANGE_RAISED;
			end else if (b == 8'hED) begin
				cont_left  = 2'd2;
				cont_range = RANGE_LOWERED;
			end else if (b >= 8'hE1 && b <= 8'hEF) begin
				cont_left = 2'd2;
			end else if (b == 8'hF0) begin
				cont_left  = 2'd3;
				cont_range = RANGE_RAISED;
			end else if (b == 8'hF4) begin
				cont_left  = 2'd3;
				cont_range = RANGE_LOWERED;
			end else if (b >= 8'hF1 && b <= 8'hF3) begin
				cont_left = 2'd3;
			end else begin
				path_bad = 1'b1;
			end
		end

		if (opening) begin
			if (b != CH_SLASH)
				path_bad = 1'b1;
		end else if (b == CH_SLASH) begin
			close_component(prev_byte);
		end else begin
			case (b)
				":", "*", "?", "\"", "<", ">", "|": path_bad = 1'b1;
				default: ;
			endcase
			if (prev_byte == CH_TILDE && b >= "0" && b <= "9")
				path_bad = 1'b1;
			if (b == CH_DOT) begin
				if (comp_len == 0)
					comp_dots = DOTS_ONE;
				else if (comp_dots == DOTS_ONE)
					comp_dots = DOTS_TWO;
				else if (comp_dots == DOTS_TWO)
					comp_dots = DOTS_MANY;
			end else begin
				comp_dots = DOTS_NONE;
			end
			if (comp_len < COMPONENT_MAX_LEN + 1)
				comp_len++;
			if (fin)
				close_component(b);
		end
		prev_byte = b;

		if (fin) begin
			if (cont_left != 2'd0 || path_len > PATH_MAX_LEN || capacity < path_len + 1)
				path_bad = 1'b1;
			// A single trailing slash is not part of the normalised length.
			norm = path_len;
			if (b == CH_SLASH && path_len > 1)
				norm--;
			verdict.path_status       = path_bad;
			verdict.normalized_length = path_bad ? '0 : CNT_W'(norm);
			owed.push_back(verdict);
			restart_path();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed.delete();
			restart_path();
			capacity      = CAP_RESET;
			fault_count   = 0;
			verdicts_owed = 0;
		end else begin
			// Verdicts are matched before this edge's byte is absorbed, so a verdict
			// that arrives with its own final byte counts as unexpected.
			if (out_valid && out_ready) begin
				if (owed.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: verdict with nothing owed: status %0b length %0d",
							$time, out_data.path_status, out_data.normalized_length);
				end else begin
					want = owed.pop_front();
					if (out_data.path_status !== want.path_status ||
					    out_data.normalized_length !== want.normalized_length) begin
						fault_count++;
						if (fault_count <= 10)
							$display({"%0t: verdict mismatch: expected status %0b length %0d,",
								" got status %0b length %0d"}, $time, want.path_status,
								want.normalized_length, out_data.path_status,
								out_data.normalized_length);
					end
				end
			end
			if (cfg_we)
				capacity = cfg_data;
			if (in_valid && in_ready)
				absorb_byte(in_data.path_byte, in_data.last_byte);
			verdicts_owed = owed.size();
		end
	end

endmodule

// File: verif/utf8_path_validator_tb.sv
`timescale 1ns / 1ps

module utf8_path_validator_tb;
	import upv_pkg::*;

	localparam int PHASES        = 7;
	localparam int PHASE_BYTES   = 90;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 120;
	localparam int CYCLE_LIMIT   = 200000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_data;

	int unsigned verdicts_owed;
	int unsigned fault_count;
	int unsigned cycle_count;
	int unsigned bytes_sent;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          hold_requests;
	int          holds_served;
	logic [7:0]  path_buf[$];

	utf8_path_validator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	upv_verdict_check verdict_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.verdicts_owed (verdicts_owed),
		.fault_count   (fault_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("utf8_path_validator_tb: errors");
			$finish;
		end
	end

	initial begin : receiver
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				// A long hold lets the verdict register and the input queue fill up.
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic [7:0] pick(input int lo, input int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	// Appends one or two characters: mostly ASCII letters, sometimes a well-formed multi-byte sequence.
	function automatic void push_symbol();
		int         r;
		logic [7:0] lead;
		r = $urandom_range(19);
		if (r < 11) begin
			path_buf.push_back(pick(8'h61, 8'h7A));
		end else if (r == 11) begin
			path_buf.push_back(pick(8'h30, 8'h39));
		end else if (r == 12) begin
			path_buf.push_back(pick(8'h41, 8'h5A));
		end else if (r == 13) begin
			path_buf.push_back(CH_DOT);
		end else if (r == 14) begin
			path_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TILDE);
		end else if (r == 15) begin
			path_buf.push_back(pick(8'hC2, 8'hDF));
			path_buf.push_back(pick(8'h80, 8'hBF));
		end else if (r == 16) begin
			lead = pick(8'hE0, 8'hEF);
			path_buf.push_back(lead);
			if (lead == 8'hE0)
				path_buf.push_back(pick(8'hA0, 8'hBF));
			else if (lead == 8'hED)
				path_buf.push_back(pick(8'h80, 8'h9F));
			else
				path_buf.push_back(pick(8'h80, 8'hBF));
			path_buf.push_back(pick(8'h80, 8'hBF));
		end else if (r == 17) begin
			lead = pick(8'hF0, 8'hF4);
			path_buf.push_back(lead);
			if (lead == 8'hF0)
				path_buf.push_back(pick(8'h90, 8'hBF));
			else if (lead == 8'hF4)
				path_buf.push_back(pick(8'h80, 8'h8F));
			else
				path_buf.push_back(pick(8'h80, 8'hBF));
			repeat (2) path_buf.push_back(pick(8'h80, 8'hBF));
		end else if (r == 18) begin
			path_buf.push_back(CH_TILDE);
			path_buf.push_back(pick(8'h61, 8'h7A));
		end else begin
			path_buf.push_back(pick(8'h21, 8'h7E));
		end
	endfunction

	// Tries to break the path in one of the ways the block must catch; a random overwrite may leave it valid.
	function automatic void spoil_path();
		int    at;
		string punct = ":*?\"<>|";
		at = $urandom_range(path_buf.size() - 1);
		case ($urandom_range(9))
			0: path_buf[at] = pick(0, 255);
			1: path_buf.insert(at, pick(0, 8'h1F));
			2: path_buf.insert(at, $urandom_range(1) ? CH_DEL : CH_BSL);
			3: path_buf.push_back(punct[$urandom_range(6)]);
			4: begin
				path_buf.push_back(CH_SLASH);
				path_buf.push_back(CH_DOT);
				if ($urandom_range(1))
					path_buf.push_back(CH_DOT);
			end
			5: path_buf.push_back($urandom_range(1) ? CH_DOT : CH_SPACE);
			6: begin
				path_buf.push_back(CH_TILDE);
				path_buf.push_back(pick(8'h30, 8'h39));
			end
			7: path_buf.push_back(pick(8'hC2, 8'hF4));
			8: begin
				case ($urandom_range(5))
					0: path_buf.push_back($urandom_range(1) ? pick(8'hC0, 8'hC1) :
						pick(8'hF5, 8'hFF));
					1: path_buf.push_back(pick(8'h80, 8'hBF));
					2: begin
						path_buf.push_back(8'hE0);
						path_buf.push_back(pick(8'h80, 8'h9F));
						path_buf.push_back(8'h80);
					end
					3: begin
						path_buf.push_back(8'hED);
						path_buf.push_back(pick(8'hA0, 8'hBF));
						path_buf.push_back(8'h80);
					end
					4: begin
						path_buf.push_back(8'hF0);
						path_buf.push_back(pick(8'h80, 8'h8F));
						repeat (2) path_buf.push_back(8'h80);
					end
					default: begin
						path_buf.push_back(8'hF4);
						path_buf.push_back(pick(8'h90, 8'hBF));
						repeat (2) path_buf.push_back(8'h80);
					end
				endcase
			end
			default: path_buf[0] = pick(0, 255);
		endcase
	endfunction

	function automatic void build_random_path();
		int parts;
		path_buf.delete();
		if ($urandom_range(11) == 0) begin
			repeat ($urandom_range(8, 1)) path_buf.push_back(pick(0, 255));
			return;
		end
		path_buf.push_back(CH_SLASH);
		parts = $urandom_range(4);
		for (int k = 0; k < parts; k++) begin
			if (k > 0)
				path_buf.push_back(CH_SLASH);
			repeat ($urandom_range(10, 1)) push_symbol();
		end
		if (parts > 0 && $urandom_range(3) == 0)
			path_buf.push_back(CH_SLASH);
		if ($urandom_range(2) == 0)
			spoil_path();
	endfunction

	// Long paths of letters with a slash after every comp letters.
	function automatic void build_uniform(input int total, input int comp);
		int run;
		path_buf.delete();
		path_buf.push_back(CH_SLASH);
		run = 0;
		while (path_buf.size() < total) begin
			if (run == comp) begin
				path_buf.push_back(CH_SLASH);
				run = 0;
			end else begin
				path_buf.push_back(pick(8'h61, 8'h7A));
				run++;
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gaps;
		gaps = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gaps++;
		if (gaps > 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= in_item_t'({b, fin});
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_path();
		int n;
		n = path_buf.size();
		for (int i = 0; i < n; i++)
			send_byte(path_buf[i], i == n - 1);
	endtask

	task automatic send_text(input string s);
		path_buf.delete();
		for (int i = 0; i < s.len(); i++)
			path_buf.push_back(s[i]);
		send_path();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdicts_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= cap;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	initial begin : stimulus
		logic [CAP_W-1:0] cap;
		int unsigned      phase_end;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		tx_idle_pct   = 15;
		rx_idle_pct   = 48;
		hold_requests = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Corner cases under the reset capacity.
		send_text("/");
		send_text("/ab/");
		send_text("ab");
		send_text("//");
		send_text("/.");
		send_text("/..");
		send_text("/a.");
		send_text("/a ");
		send_text("/a:b");
		send_text("/a\\b");
		send_text("/a\037");
		send_text("/\177");
		send_text("/~1");
		send_text("/~a");
		send_text("/\303\251");
		send_text("/\340\240\200");
		send_text("/\340\237\277");
		send_text("/\355\237\277");
		send_text("/\355\240\200");
		send_text("/\360\220\200\200");
		send_text("/\360\217\277\277");
		send_text("/\364\217\277\277");
		send_text("/\364\220\200\200");
		send_text("/\300\257");
		send_text("/\303");
		send_text("/\303A\251");

		for (int p = 0; p < PHASES; p++) begin
			tx_idle_pct = (p < 3) ? 15 : (p < 5) ? 48 : 0;
			rx_idle_pct = (p < 3) ? 48 : (p < 5) ? 15 : 0;
			case (p)
				0: cap = CAP_W'(2);
				1: cap = CAP_W'(0);
				2: cap = CAP_W'(30);
				3: cap = CAP_W'(2047);
				4: cap = CAP_W'(1024);
				5: cap = CAP_RESET;
				default: cap = CAP_W'($urandom_range(2047));
			endcase
			write_capacity(cap);
			if (p == 2 || p == 5)
				hold_requests++;
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				build_random_path();
				send_path();
			end
			if (p == 3) begin
				build_uniform(256, 255);
				send_path();
				build_uniform(257, 256);
				send_path();
			end
		end

		drain();
		if (fault_count == 0)
			$display("utf8_path_validator_tb: clean");
		else
			$display("utf8_path_validator_tb: errors");
		$finish;
	end

endmodule

// File: sim.f
sv/upv_pkg.sv
sv/upv_front.sv
sv/upv_queue.sv
sv/upv_back.sv
sv/utf8_path_validator.sv
verif/upv_verdict_check.sv
verif/utf8_path_validator_tb.sv
